### hw/rtl/sle_pkg.sv
// Package for the sorted list engine: transaction types, action codes and
// fixed field widths. No dependencies; imported by every module of the block.
package sle_pkg;

	localparam int DATA_W      = 32;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic signed [DATA_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic                      hit;
		logic                      overflow;
		logic [COUNT_OUT_W-1:0]    entry_count;
		logic                      is_empty;
		logic signed [DATA_W-1:0]  smallest;
		logic signed [DATA_W-1:0]  largest;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
	} dp_cmd_t;

endpackage

### hw/rtl/sle_ctrl.sv
// Controller of the sorted list engine: accept/update sequencing and the
// output valid flag. Depends on sle_pkg.
module sle_ctrl
	import sle_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.update  = (state_q == ST_UPDATE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// The store changes only once the previous result has left,
					// since the result summary is read from the store.
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.update))
		else $error("capture and update in the same cycle");

	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("input still ready after a capture");

	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid)
		else $error("update did not present a result");

endmodule

### hw/rtl/sle_datapath.sv
// Datapath of the sorted list engine: entry lanes with per-lane compare,
// shift-up on insert, shift-down on remove, count and result summary.
// Depends on sle_pkg.
module sle_datapath
	import sle_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  in_data,
	output out_item_t result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [DATA_W-1:0] entries_q [CAPACITY];
	logic [CW-1:0]            count_q;
	logic [CAPACITY-1:0]      valid;
	logic [CAPACITY-1:0]      last;
	logic [CAPACITY-1:0]      place;

	// Stage registers filled when a transaction is accepted.
	action_t                  action_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [CAPACITY-1:0]      gt_s1;
	logic [CAPACITY-1:0]      eq_s1;

	logic                     hit_q;
	logic                     ovf_q;
	logic                     full;
	logic                     found;
	logic signed [DATA_W-1:0] largest_sel;

	assign full  = (count_q == CW'(CAPACITY));
	assign found = |eq_s1;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_lane
		assign valid[k] = (count_q > CW'(k));

		if (k == CAPACITY - 1) begin : g_top
			assign last[k] = valid[k];
		end else begin : g_mid
			assign last[k] = valid[k] && !valid[k+1];
		end

		// The new value lands where the entry below stays and this entry
		// either moves up or is the first free slot.
		if (k == 0) begin : g_place0
			assign place[k] = gt_s1[k] || !valid[k];
		end else begin : g_placek
			assign place[k] = !gt_s1[k-1] && (gt_s1[k] || (!valid[k] && valid[k-1]));
		end

		always_ff @(posedge clk) begin
			if (cmd.capture) begin
				gt_s1[k] <= valid[k] && (entries_q[k] > in_data.value);
				eq_s1[k] <= valid[k] && (entries_q[k] == in_data.value);
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				if (action_s1 == ACT_INSERT && !full) begin
					if (place[k]) begin
						entries_q[k] <= value_s1;
					end else if (k > 0 && gt_s1[(k > 0) ? k-1 : 0]) begin
						entries_q[k] <= entries_q[(k > 0) ? k-1 : 0];
					end
				end else if (action_s1 == ACT_REMOVE && found) begin
					// Sorted order puts the first equal entry at the lowest
					// lane holding a value not below the operand.
					if ((gt_s1[k] || eq_s1[k]) && k < CAPACITY - 1) begin
						entries_q[k] <= entries_q[(k < CAPACITY - 1) ? k+1 : k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_s1 <= in_data.action;
			value_s1  <= in_data.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.update) begin
			hit_q <= 1'b0;
			ovf_q <= 1'b0;
			unique case (action_s1)
				ACT_INSERT: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				ACT_REMOVE: begin
					if (found) begin
						hit_q   <= 1'b1;
						count_q <= count_q - CW'(1);
					end
				end
				ACT_LOOKUP: begin
					hit_q <= found;
				end
				ACT_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_comb begin
		largest_sel = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			largest_sel = largest_sel | (entries_q[k] & {DATA_W{last[k]}});
		end
	end

	assign result.hit         = hit_q;
	assign result.overflow    = ovf_q;
	assign result.entry_count = COUNT_OUT_W'(count_q);
	assign result.is_empty    = (count_q == '0);
	assign result.smallest    = (count_q == '0) ? '0 : entries_q[0];
	assign result.largest     = largest_sel;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_last_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(last))
		else $error("more than one last entry");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && action_s1 == ACT_REMOVE && found
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove hit did not decrement the count");

endmodule

### hw/rtl/sorted_list_engine.sv
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order and serves insert, remove-first-equal, lookup and clear. Each
// transaction has a compare step, in which the accepting edge registers a
// compare of the operand against every stored entry in parallel, and an
// update step that shifts the entry lanes and loads the result; the input
// is ready again in the cycle after the update. The result summary is read
// from the store, so an accepted transaction waits in its update step until
// the previous result is taken. No clearing pass is needed after reset.
module sorted_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t cmd;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sle_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.result  (out_data)
	);

endmodule
